>>> design/assert_macros.svh
// Assertion helpers, checked in simulation only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed in list engine");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_AT(label, clk, rst_n, !(cond))

`else

`define ASSERT_AT(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> design/rrl_pkg.sv
`default_nettype none

package rrl_pkg;

    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] data_in;
    } t_in_req;

    typedef struct packed {
        logic [WORD_W-1:0]  data_out;
        logic               success;
        logic [COUNT_W-1:0] entry_count;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP2,
        ST_NXT,
        ST_DEL1,
        ST_DEL2,
        ST_DEL3,
        ST_DEL4,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> design/rrl_ram.sv
`default_nettype none

module rrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/round_robin_list_engine.sv
// Channel   Valid        Stall         Payload
// request   i_in_valid   o_in_stall    i_in  (rrl_pkg::t_in_req)
// result    o_out_valid  i_out_stall   o_out (rrl_pkg::t_out_req)
// config    i_cfg_we     -             i_cfg_wdata
//
// A failed or trivial command goes straight to ST_DONE; otherwise append passes
// ST_APP2, next ST_NXT, delete from two or more entries ST_DEL1 to ST_DEL3/4.
// Delete is bound by the chain of dependent reads through the prev-link table.
// One request in flight; the result register lets the next request in while
// a result waits. Synchronous active-low reset; the tables are not cleared.
`default_nettype none

module round_robin_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_stall,
    input  wire rrl_pkg::t_in_req               i_in,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    output      rrl_pkg::t_out_req              o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrl_pkg::COUNT_W-1:0]    i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int SW      = $clog2(CAPACITY);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int COUNT_W = rrl_pkg::COUNT_W;
    localparam int WORD_W  = rrl_pkg::WORD_W;
    localparam int XW      = (CW > COUNT_W) ? CW : COUNT_W;

    rrl_pkg::t_state r_state, n_state;

    logic [SW-1:0]         r_head, n_head;
    logic [SW-1:0]         r_tail, n_tail;
    logic [SW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_count, n_count;
    logic [COUNT_W-1:0]    r_cap;
    logic [SW-1:0]         r_v, n_v;
    logic [SW-1:0]         r_p, n_p;
    logic [SW-1:0]         r_n, n_n;
    logic [SW-1:0]         r_last, n_last;
    logic [SW-1:0]         r_nlast, n_nlast;
    logic [DATA_WIDTH-1:0] r_dlast, n_dlast;
    logic [SW-1:0]         r_nn, n_nn;
    logic [SW-1:0]         r_pp, n_pp;
    logic [WORD_W-1:0]     r_dres, n_dres;
    logic                  r_ok, n_ok;
    rrl_pkg::t_out_req     r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  w_dat_we;
    logic [SW-1:0]         w_dat_waddr, w_dat_raddr;
    logic [DATA_WIDTH-1:0] w_dat_wdata, w_dat_rdata;
    logic                  w_nxt_we;
    logic [SW-1:0]         w_nxt_waddr, w_nxt_raddr, w_nxt_wdata, w_nxt_rdata;
    logic                  w_prv_we;
    logic [SW-1:0]         w_prv_waddr, w_prv_raddr, w_prv_wdata, w_prv_rdata;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_out_free;
    logic [SW-1:0]         w_slot_new;
    logic [SW-1:0]         w_last;

    rrl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_dat_we),
        .i_waddr (w_dat_waddr),
        .i_wdata (w_dat_wdata),
        .i_raddr (w_dat_raddr),
        .o_rdata (w_dat_rdata)
    );

    rrl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nxt_we),
        .i_waddr (w_nxt_waddr),
        .i_wdata (w_nxt_wdata),
        .i_raddr (w_nxt_raddr),
        .o_rdata (w_nxt_rdata)
    );

    rrl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prv_we),
        .i_waddr (w_prv_waddr),
        .i_wdata (w_prv_wdata),
        .i_raddr (w_prv_raddr),
        .o_rdata (w_prv_rdata)
    );

    assign w_accept   = i_in_valid && (r_state == rrl_pkg::ST_IDLE);
    assign w_full     = (r_count >= CW'(CAPACITY)) || (XW'(r_count) >= XW'(r_cap));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_slot_new = SW'(r_count);
    assign w_last     = SW'(r_count - CW'(1));

    assign o_in_stall  = (r_state != rrl_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.command)
                        rrl_pkg::CMD_APPEND: begin
                            n_state = (w_full || r_count == '0) ? rrl_pkg::ST_DONE
                                                                : rrl_pkg::ST_APP2;
                        end
                        rrl_pkg::CMD_NEXT: begin
                            n_state = (r_count == '0) ? rrl_pkg::ST_DONE : rrl_pkg::ST_NXT;
                        end
                        rrl_pkg::CMD_DELETE: begin
                            n_state = (r_count <= CW'(1)) ? rrl_pkg::ST_DONE
                                                          : rrl_pkg::ST_DEL1;
                        end
                        default: begin
                            n_state = rrl_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            rrl_pkg::ST_APP2: n_state = rrl_pkg::ST_DONE;
            rrl_pkg::ST_NXT:  n_state = rrl_pkg::ST_DONE;
            rrl_pkg::ST_DEL1: n_state = rrl_pkg::ST_DEL2;
            rrl_pkg::ST_DEL2: n_state = rrl_pkg::ST_DEL3;
            rrl_pkg::ST_DEL3: begin
                n_state = (r_last != r_v) ? rrl_pkg::ST_DEL4 : rrl_pkg::ST_DONE;
            end
            rrl_pkg::ST_DEL4: n_state = rrl_pkg::ST_DONE;
            rrl_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = rrl_pkg::ST_IDLE;
                end
            end
            default: n_state = rrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        logic [SW-1:0] v_nn;
        logic [SW-1:0] v_pp;

        v_nn        = '0;
        v_pp        = '0;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_v         = r_v;
        n_p         = r_p;
        n_n         = r_n;
        n_last      = r_last;
        n_nlast     = r_nlast;
        n_dlast     = r_dlast;
        n_nn        = r_nn;
        n_pp        = r_pp;
        n_dres      = r_dres;
        n_ok        = r_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        w_dat_we    = 1'b0;
        w_dat_waddr = w_slot_new;
        w_dat_wdata = DATA_WIDTH'(i_in.data_in);
        w_dat_raddr = r_cursor;
        w_nxt_we    = 1'b0;
        w_nxt_waddr = w_slot_new;
        w_nxt_wdata = r_head;
        w_nxt_raddr = r_cursor;
        w_prv_we    = 1'b0;
        w_prv_waddr = w_slot_new;
        w_prv_wdata = r_tail;
        w_prv_raddr = r_cursor;

        unique case (r_state)
            rrl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_dres = '0;
                    n_ok   = 1'b0;
                    unique case (i_in.command)
                        rrl_pkg::CMD_APPEND: begin
                            if (!w_full) begin
                                n_ok     = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_last   = w_slot_new;
                                w_dat_we = 1'b1;
                                w_nxt_we = 1'b1;
                                w_prv_we = 1'b1;
                                if (r_count == '0) begin
                                    w_nxt_wdata = w_slot_new;
                                    w_prv_wdata = w_slot_new;
                                    n_head      = w_slot_new;
                                    n_tail      = w_slot_new;
                                    n_cursor    = w_slot_new;
                                end
                            end
                        end
                        rrl_pkg::CMD_NEXT: begin
                            n_ok = (r_count != '0);
                        end
                        rrl_pkg::CMD_DELETE: begin
                            if (r_count == CW'(1)) begin
                                n_ok     = 1'b1;
                                n_count  = '0;
                                n_head   = '0;
                                n_tail   = '0;
                                n_cursor = '0;
                            end else if (r_count != '0) begin
                                n_ok        = 1'b1;
                                n_count     = r_count - CW'(1);
                                n_last      = w_last;
                                w_nxt_raddr = w_last;
                                w_dat_raddr = w_last;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            rrl_pkg::ST_APP2: begin
                w_nxt_we    = 1'b1;
                w_nxt_waddr = r_tail;
                w_nxt_wdata = r_last;
                w_prv_we    = 1'b1;
                w_prv_waddr = r_head;
                w_prv_wdata = r_last;
                n_tail      = r_last;
            end
            rrl_pkg::ST_NXT: begin
                n_dres   = WORD_W'(w_dat_rdata);
                n_cursor = w_nxt_rdata;
            end
            rrl_pkg::ST_DEL1: begin
                n_v         = w_prv_rdata;
                n_nlast     = w_nxt_rdata;
                n_dlast     = w_dat_rdata;
                w_prv_raddr = w_prv_rdata;
                w_nxt_raddr = w_prv_rdata;
            end
            rrl_pkg::ST_DEL2: begin
                // unlink the victim
                n_p         = w_prv_rdata;
                n_n         = w_nxt_rdata;
                w_nxt_we    = 1'b1;
                w_nxt_waddr = w_prv_rdata;
                w_nxt_wdata = w_nxt_rdata;
                w_prv_we    = 1'b1;
                w_prv_waddr = w_nxt_rdata;
                w_prv_wdata = w_prv_rdata;
                w_prv_raddr = r_last;
                if (r_head == r_v) begin
                    n_head = w_nxt_rdata;
                end
                if (r_tail == r_v) begin
                    n_tail = w_prv_rdata;
                end
            end
            rrl_pkg::ST_DEL3: begin
                // move the last slot into the hole; links of last seen after unlink
                if (r_last != r_v) begin
                    v_nn = (r_p == r_last) ? r_n : r_nlast;
                    v_pp = (r_n == r_last) ? r_p : w_prv_rdata;
                    if (v_nn == r_last) begin
                        v_nn = r_v;
                    end
                    if (v_pp == r_last) begin
                        v_pp = r_v;
                    end
                    n_nn        = v_nn;
                    n_pp        = v_pp;
                    w_dat_we    = 1'b1;
                    w_dat_waddr = r_v;
                    w_dat_wdata = r_dlast;
                    w_nxt_we    = 1'b1;
                    w_nxt_waddr = r_v;
                    w_nxt_wdata = v_nn;
                    w_prv_we    = 1'b1;
                    w_prv_waddr = r_v;
                    w_prv_wdata = v_pp;
                    if (r_head == r_last) begin
                        n_head = r_v;
                    end
                    if (r_tail == r_last) begin
                        n_tail = r_v;
                    end
                    if (r_cursor == r_last) begin
                        n_cursor = r_v;
                    end
                end
            end
            rrl_pkg::ST_DEL4: begin
                w_nxt_we    = 1'b1;
                w_nxt_waddr = r_pp;
                w_nxt_wdata = r_v;
                w_prv_we    = 1'b1;
                w_prv_waddr = r_nn;
                w_prv_wdata = r_v;
            end
            rrl_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.data_out    = r_dres;
                    n_out.success     = r_ok;
                    n_out.entry_count = COUNT_W'(r_count);
                end
            end
            default: begin
                n_ok = r_ok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrl_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_cursor    <= '0;
            r_count     <= '0;
            r_cap       <= rrl_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_p     <= n_p;
        r_n     <= n_n;
        r_last  <= n_last;
        r_nlast <= n_nlast;
        r_dlast <= n_dlast;
        r_nn    <= n_nn;
        r_pp    <= n_pp;
        r_dres  <= n_dres;
        r_ok    <= n_ok;
        r_out   <= n_out;
    end

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(CAPACITY))

    `ASSERT_AT(a_done_to_idle, i_clk, i_rst_n, (r_state == rrl_pkg::ST_DONE && w_out_free) |=> (r_state == rrl_pkg::ST_IDLE && r_out_valid))

    `ASSERT_AT(a_ptrs_live, i_clk, i_rst_n, (r_state == rrl_pkg::ST_IDLE && r_count != '0) |-> (CW'(r_cursor) < r_count && CW'(r_head) < r_count && CW'(r_tail) < r_count))

    `ASSERT_AT(a_empty_ptrs, i_clk, i_rst_n, (r_state == rrl_pkg::ST_IDLE && r_count == '0) |-> (r_cursor == '0 && r_head == '0 && r_tail == '0))

endmodule

`default_nettype wire
